>>> hdl/fne_pkg.sv
`timescale 1ns / 1ps
// shared widths, codes, descriptor type and neighbour offset table
// for the fcc neighbour enumerator; no dependencies

package fne_pkg;

  localparam int COORD_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int SIZE_W    = 5;
  localparam int SLOT_W    = 5;
  localparam int IDX_W     = 30;
  localparam int STATUS_W  = 2;
  localparam int N_SLOT    = 18;
  localparam int N_FIRST   = 12;
  localparam int PLANE_W   = 2 * COUNT_W;
  localparam int REG_IDX_W = 2;

  localparam int DEF_MAX_SIDE    = 1024;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAYER_COUNT  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NBHD_SIZE    = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_FIRST  = 5'd12;
  localparam logic [SIZE_W-1:0] SIZE_SECOND = 5'd18;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

  localparam logic [STATUS_W-1:0] ST_NEIGHBOR = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SIZE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
    logic signed [2:0] dl;
  } offset_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [N_SLOT-1:0]   mask;
    logic                parity;
    logic [IDX_W-1:0]    base;
    logic [PLANE_W-1:0]  plane;
    logic [COUNT_W-1:0]  ncol;
  } desc_t;

  function automatic offset_t mk_offset(int dr, int dc, int dl);
    offset_t o;
    o.dr = 3'(dr);
    o.dc = 3'(dc);
    o.dl = 3'(dl);
    return o;
  endfunction

  // parity high: offset row (row + layer odd)
  function automatic offset_t slot_offset(logic [SLOT_W-1:0] slot, logic parity);
    offset_t o;
    case (slot)
      5'd0:    o = mk_offset(-1, 0, -1);
      5'd1:    o = mk_offset(-1, parity ? 0 : -1, 0);
      5'd2:    o = mk_offset(-1, 0, 1);
      5'd3:    o = mk_offset(-1, parity ? 1 : 0, 0);
      5'd4:    o = mk_offset(0, parity ? 0 : -1, -1);
      5'd5:    o = mk_offset(0, parity ? 0 : -1, 1);
      5'd6:    o = mk_offset(0, parity ? 1 : 0, 1);
      5'd7:    o = mk_offset(0, parity ? 1 : 0, -1);
      5'd8:    o = mk_offset(1, 0, -1);
      5'd9:    o = mk_offset(1, parity ? 0 : -1, 0);
      5'd10:   o = mk_offset(1, 0, 1);
      5'd11:   o = mk_offset(1, parity ? 1 : 0, 0);
      5'd12:   o = mk_offset(-2, 0, 0);
      5'd13:   o = mk_offset(0, 0, -2);
      5'd14:   o = mk_offset(0, -1, 0);
      5'd15:   o = mk_offset(0, 0, 2);
      5'd16:   o = mk_offset(0, 1, 0);
      5'd17:   o = mk_offset(2, 0, 0);
      default: o = mk_offset(0, 0, 0);
    endcase
    return o;
  endfunction

endpackage

>>> hdl/fne_front.sv
`timescale 1ns / 1ps
// front end: accepts a centre, classifies it, builds the in-bounds slot mask
// and the base linear index; depends on fne_pkg

module fne_front import fne_pkg::*; #(
  parameter int MAX_SIDE    = DEF_MAX_SIDE,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int CNT_W       = $clog2(DEF_QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [COORD_W-1:0] in_center_row,
  input  logic [COORD_W-1:0] in_center_column,
  input  logic [COORD_W-1:0] in_center_layer,
  input  logic [COUNT_W-1:0] row_count,
  input  logic [COUNT_W-1:0] column_count,
  input  logic [COUNT_W-1:0] layer_count,
  input  logic [SIZE_W-1:0]  neighborhood_size,
  input  logic [CNT_W-1:0]   q_count,
  output logic               q_push,
  output desc_t              q_data
);

  localparam int COUNT_MAX = 2 ** COUNT_W - 1;
  localparam int SIDE_CAP  = (MAX_SIDE > COUNT_MAX) ? COUNT_MAX : MAX_SIDE;
  localparam logic [COUNT_W-1:0] SIDE_CAP_V = COUNT_W'(SIDE_CAP);
  localparam int PROD_W = PLANE_W + COORD_W;

  function automatic logic [COUNT_W-1:0] clamp(logic [COUNT_W-1:0] v);
    return (v > SIDE_CAP_V) ? SIDE_CAP_V : v;
  endfunction

  function automatic logic axis_ok(logic [COORD_W-1:0] v, logic [COUNT_W-1:0] n,
                                   logic [2:0] d);
    logic [COORD_W+1:0] p;
    p = {2'b00, v} + {{(COORD_W - 1){d[2]}}, d};
    return !p[COORD_W+1] && (p[COUNT_W-1:0] < n);
  endfunction

  logic               accept;
  logic               s1_v_r;
  logic [COORD_W-1:0] s1_row_r, s1_col_r, s1_lay_r;
  logic [COUNT_W-1:0] s1_nr_r, s1_nc_r, s1_nl_r;
  logic               s1_bad_r, s1_large_r;

  logic [STATUS_W-1:0] s2_status_nxt;
  logic [N_SLOT-1:0]   s2_mask_nxt;
  logic                s2_par_nxt;
  logic [PLANE_W-1:0]  s2_plane_nxt, s2_rc_nxt;

  logic                s2_v_r;
  logic [STATUS_W-1:0] s2_status_r;
  logic [N_SLOT-1:0]   s2_mask_r;
  logic                s2_par_r;
  logic [PLANE_W-1:0]  s2_plane_r, s2_rc_r;
  logic [COUNT_W-1:0]  s2_nc_r;
  logic [COORD_W-1:0]  s2_lay_r;

  logic [PROD_W-1:0] layer_prod;

  assign in_full = ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_v_r) + (CNT_W + 1)'(s2_v_r))
                   >= (CNT_W + 1)'(QUEUE_DEPTH);
  assign accept  = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
    if (accept) begin
      s1_row_r   <= in_center_row;
      s1_col_r   <= in_center_column;
      s1_lay_r   <= in_center_layer;
      s1_nr_r    <= clamp(row_count);
      s1_nc_r    <= clamp(column_count);
      s1_nl_r    <= clamp(layer_count);
      s1_bad_r   <= (neighborhood_size != SIZE_FIRST) && (neighborhood_size != SIZE_SECOND);
      s1_large_r <= (neighborhood_size == SIZE_SECOND);
    end
    if (s1_v_r) begin
      s2_status_r <= s2_status_nxt;
      s2_mask_r   <= s2_mask_nxt;
      s2_par_r    <= s2_par_nxt;
      s2_plane_r  <= s2_plane_nxt;
      s2_rc_r     <= s2_rc_nxt;
      s2_nc_r     <= s1_nc_r;
      s2_lay_r    <= s1_lay_r;
    end
  end

  always_comb begin
    offset_t off;
    logic    out_rng;
    s2_par_nxt = s1_row_r[0] ^ s1_lay_r[0];
    for (int s = 0; s < N_SLOT; s++) begin
      off = slot_offset(SLOT_W'(s), s2_par_nxt);
      s2_mask_nxt[s] = axis_ok(s1_row_r, s1_nr_r, off.dr)
                       && axis_ok(s1_col_r, s1_nc_r, off.dc)
                       && axis_ok(s1_lay_r, s1_nl_r, off.dl)
                       && ((s < N_FIRST) || s1_large_r);
    end
    out_rng = ({1'b0, s1_row_r} >= s1_nr_r) || ({1'b0, s1_col_r} >= s1_nc_r)
              || ({1'b0, s1_lay_r} >= s1_nl_r);
    if (s1_bad_r) begin
      s2_status_nxt = ST_SIZE;
    end else if (out_rng) begin
      s2_status_nxt = ST_RANGE;
    end else if (s2_mask_nxt == '0) begin
      s2_status_nxt = ST_NONE;
    end else begin
      s2_status_nxt = ST_NEIGHBOR;
    end
    s2_plane_nxt = PLANE_W'(s1_nr_r) * PLANE_W'(s1_nc_r);
    s2_rc_nxt    = PLANE_W'(s1_row_r) * PLANE_W'(s1_nc_r) + PLANE_W'(s1_col_r);
  end

  assign layer_prod = PROD_W'(s2_lay_r) * PROD_W'(s2_plane_r);

  assign q_push        = s2_v_r;
  assign q_data.status = s2_status_r;
  assign q_data.mask   = s2_mask_r;
  assign q_data.parity = s2_par_r;
  assign q_data.base   = layer_prod[IDX_W-1:0] + IDX_W'(s2_rc_r);
  assign q_data.plane  = s2_plane_r;
  assign q_data.ncol   = s2_nc_r;

endmodule

>>> hdl/fne_queue.sv
`timescale 1ns / 1ps
// descriptor queue between the front end and the slot walker
// depends on fne_pkg

module fne_queue import fne_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  parameter int CNT_W = $clog2(DEF_QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  desc_t            push_data,
  input  logic             pop,
  output desc_t            pop_data,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(DEPTH) || pop))
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("descriptor queue underflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_r) + CNT_W'($past(push)) - CNT_W'($past(pop)))
    else $error("descriptor queue count mismatch");
`endif

endmodule

>>> hdl/fne_back.sv
`timescale 1ns / 1ps
// back end: walks one descriptor's slot mask per request, one result a cycle
// while there is room, into a two-entry result queue; depends on fne_pkg

module fne_back import fne_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  desc_t               q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [IDX_W-1:0]    out_neighbor_index,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last
);

  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [IDX_W-1:0]    idx;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  function automatic logic [IDX_W-1:0] term(logic [2:0] d, logic [IDX_W-1:0] x);
    logic [IDX_W-1:0] t;
    case (d)
      3'b001:  t = x;
      3'b010:  t = x << 1;
      3'b111:  t = -x;
      3'b110:  t = -(x << 1);
      default: t = '0;
    endcase
    return t;
  endfunction

  desc_t             cur_r, cur_nxt;
  logic              cur_v_r, cur_v_nxt;
  logic [N_SLOT-1:0] rem_r, rem_nxt, rem_clr;
  logic [SLOT_W-1:0] sel;
  offset_t           off;
  result_t           res;
  logic              emit, done, space, pop_fire;

  result_t          mem_r [OUT_DEPTH];
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wptr_r, rptr_r;

  assign pop_fire = out_pop && (cnt_r != 2'd0);
  assign space    = (cnt_r != 2'(OUT_DEPTH)) || pop_fire;

  always_comb begin
    sel = '0;
    for (int s = N_SLOT - 1; s >= 0; s--) begin
      if (rem_r[s]) begin
        sel = SLOT_W'(s);
      end
    end
    rem_clr = rem_r & ~(N_SLOT'(1) << sel);
    off     = slot_offset(sel, cur_r.parity);
    if (cur_r.status != ST_NEIGHBOR) begin
      res.slot   = '0;
      res.idx    = '0;
      res.status = cur_r.status;
      res.last   = 1'b1;
    end else begin
      res.slot   = sel;
      res.idx    = cur_r.base + term(off.dl, IDX_W'(cur_r.plane))
                   + term(off.dr, IDX_W'(cur_r.ncol))
                   + {{(IDX_W - 3){off.dc[2]}}, off.dc};
      res.status = ST_NEIGHBOR;
      res.last   = (rem_clr == '0);
    end
    emit  = cur_v_r && space;
    done  = emit && res.last;
    q_pop = !q_empty && (!cur_v_r || done);

    cur_nxt   = q_pop ? q_data : cur_r;
    cur_v_nxt = q_pop || (cur_v_r && !done);
    if (q_pop) begin
      rem_nxt = q_data.mask;
    end else if (emit) begin
      rem_nxt = rem_clr;
    end else begin
      rem_nxt = rem_r;
    end
    cnt_nxt = cnt_r + 2'(emit) - 2'(pop_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      cnt_r   <= 2'd0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      cnt_r   <= cnt_nxt;
      wptr_r  <= wptr_r ^ emit;
      rptr_r  <= rptr_r ^ pop_fire;
    end
    cur_r <= cur_nxt;
    rem_r <= rem_nxt;
    if (emit) begin
      mem_r[wptr_r] <= res;
    end
  end

  assign out_empty          = (cnt_r == 2'd0);
  assign out_slot           = mem_r[rptr_r].slot;
  assign out_neighbor_index = mem_r[rptr_r].idx;
  assign out_status         = mem_r[rptr_r].status;
  assign out_last           = mem_r[rptr_r].last;

`ifndef SYNTHESIS
  a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(OUT_DEPTH))
    else $error("result queue count out of range");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_NEIGHBOR)
      |-> (out_last && out_slot == '0 && out_neighbor_index == '0))
    else $error("status result malformed");

  a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_v_r && cur_r.status == ST_NEIGHBOR) |-> rem_r != '0)
    else $error("walker holds exhausted request");
`endif

endmodule

>>> hdl/fcc_neighbor_enumerator.sv
`timescale 1ns / 1ps
// Each accepted centre yields one result per in-bounds neighbour (up to 18,
// in slot order) or a single status result. The front end is a two-stage
// pipeline that takes a new centre every cycle while the descriptor queue
// has room; a centre passes its stage-one and stage-two registers before it
// is pushed into the queue. The slot walker in the back end issues one result
// per cycle while the result queue has room, so a centre occupies it until
// all its results (1 to 18) are issued, and that walker sets the sustained
// rate. Results wait in a two-entry queue. There is no clearing pass after
// reset. Configuration writes are always taken (cfg_ready is tied high).
// Depends on fne_pkg, fne_front, fne_queue and fne_back.

module fcc_neighbor_enumerator import fne_pkg::*; #(
  parameter int MAX_SIDE    = DEF_MAX_SIDE,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [COORD_W-1:0]   in_center_row,
  input  logic [COORD_W-1:0]   in_center_column,
  input  logic [COORD_W-1:0]   in_center_layer,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [IDX_W-1:0]     out_neighbor_index,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [COUNT_W-1:0] row_count_r, column_count_r, layer_count_r;
  logic [SIZE_W-1:0]  nbhd_size_r;

  logic             q_push, q_pop, q_empty;
  desc_t            q_in, q_out;
  logic [CNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= COUNT_RESET;
      column_count_r <= COUNT_RESET;
      layer_count_r  <= COUNT_RESET;
      nbhd_size_r    <= SIZE_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_data;
        REG_COLUMN_COUNT: column_count_r <= cfg_data;
        REG_LAYER_COUNT:  layer_count_r  <= cfg_data;
        REG_NBHD_SIZE:    nbhd_size_r    <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fne_front #(
    .MAX_SIDE    (MAX_SIDE),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_center_row     (in_center_row),
    .in_center_column  (in_center_column),
    .in_center_layer   (in_center_layer),
    .row_count         (row_count_r),
    .column_count      (column_count_r),
    .layer_count       (layer_count_r),
    .neighborhood_size (nbhd_size_r),
    .q_count           (q_count),
    .q_push            (q_push),
    .q_data            (q_in)
  );

  fne_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CNT_W (CNT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .count     (q_count)
  );

  fne_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_out),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_slot           (out_slot),
    .out_neighbor_index (out_neighbor_index),
    .out_status         (out_status),
    .out_last           (out_last)
  );

endmodule

>>> tb/tb_fcc_neighbor_enumerator.sv
`timescale 1ns / 1ps
// self-checking bench for fcc_neighbor_enumerator: directed and random centres,
// predicted neighbour lists checked in order against the result queue
// depends on fne_pkg and the fcc_neighbor_enumerator rtl

module tb_fcc_neighbor_enumerator;
  import fne_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;

  localparam int ALIGNED_STEP [12][3] = '{
    '{-1, 0, -1}, '{-1, -1, 0}, '{-1, 0, 1}, '{-1, 0, 0},
    '{0, -1, -1}, '{0, -1, 1}, '{0, 0, 1}, '{0, 0, -1},
    '{1, 0, -1}, '{1, -1, 0}, '{1, 0, 1}, '{1, 0, 0}
  };
  localparam int OFFSET_STEP [12][3] = '{
    '{-1, 0, -1}, '{-1, 0, 0}, '{-1, 0, 1}, '{-1, 1, 0},
    '{0, 0, -1}, '{0, 0, 1}, '{0, 1, 1}, '{0, 1, -1},
    '{1, 0, -1}, '{1, 0, 0}, '{1, 0, 1}, '{1, 1, 0}
  };
  localparam int OUTER_STEP [6][3] = '{
    '{-2, 0, 0}, '{0, 0, -2}, '{0, -1, 0}, '{0, 0, 2}, '{0, 1, 0}, '{2, 0, 0}
  };

  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic [IDX_W-1:0]    index;
    logic [STATUS_W-1:0] status;
    logic                last;
  } neighbor_rec_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_data;
  logic                 in_push;
  logic                 in_full;
  logic [COORD_W-1:0]   in_center_row;
  logic [COORD_W-1:0]   in_center_column;
  logic [COORD_W-1:0]   in_center_layer;
  logic                 out_empty;
  logic                 out_pop;
  logic [SLOT_W-1:0]    out_slot;
  logic [IDX_W-1:0]     out_neighbor_index;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_last;

  logic [COUNT_W-1:0] row_cnt;
  logic [COUNT_W-1:0] col_cnt;
  logic [COUNT_W-1:0] layer_cnt;
  logic [SIZE_W-1:0]  nbhd_size;

  neighbor_rec_t pending_neighbors[$];
  neighbor_rec_t head_rec;
  int            mismatch_count;
  int            quiet_cycles;
  int            send_idle_pct;
  int            recv_stall_pct;

  fcc_neighbor_enumerator uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_center_row      (in_center_row),
    .in_center_column   (in_center_column),
    .in_center_layer    (in_center_layer),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_slot           (out_slot),
    .out_neighbor_index (out_neighbor_index),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int side_of(input logic [COUNT_W-1:0] v);
    return (v > DEF_MAX_SIDE) ? DEF_MAX_SIDE : int'(v);
  endfunction

  task automatic append_expected(input neighbor_rec_t rec);
    pending_neighbors.insert(pending_neighbors.size(), rec);
  endtask

  task automatic push_status(input logic [STATUS_W-1:0] code);
    neighbor_rec_t rec;
    rec.slot   = '0;
    rec.index  = '0;
    rec.status = code;
    rec.last   = 1'b1;
    append_expected(rec);
  endtask

  task automatic enumerate_neighbors(input logic [COORD_W-1:0] r, c, l);
    int            nr, nc, nl, total, s, dr, dc, dl, rr, cc, ll, last_slot;
    logic          odd_row;
    logic [17:0]   hit;
    longint        lin [18];
    neighbor_rec_t rec;
    nr = side_of(row_cnt);
    nc = side_of(col_cnt);
    nl = side_of(layer_cnt);
    if (nbhd_size != SIZE_FIRST && nbhd_size != SIZE_SECOND) begin
      push_status(ST_SIZE);
      return;
    end
    if (int'(r) >= nr || int'(c) >= nc || int'(l) >= nl) begin
      push_status(ST_RANGE);
      return;
    end
    odd_row   = r[0] ^ l[0];
    total     = (nbhd_size == SIZE_SECOND) ? 18 : 12;
    hit       = '0;
    last_slot = -1;
    for (s = 0; s < total; s++) begin
      if (s >= 12) begin
        dr = OUTER_STEP[s-12][0];
        dc = OUTER_STEP[s-12][1];
        dl = OUTER_STEP[s-12][2];
      end else if (odd_row) begin
        dr = OFFSET_STEP[s][0];
        dc = OFFSET_STEP[s][1];
        dl = OFFSET_STEP[s][2];
      end else begin
        dr = ALIGNED_STEP[s][0];
        dc = ALIGNED_STEP[s][1];
        dl = ALIGNED_STEP[s][2];
      end
      rr = int'(r) + dr;
      cc = int'(c) + dc;
      ll = int'(l) + dl;
      lin[s] = 0;
      if (rr >= 0 && rr < nr && cc >= 0 && cc < nc && ll >= 0 && ll < nl) begin
        hit[s]    = 1'b1;
        lin[s]    = longint'(ll) * nr * nc + longint'(rr) * nc + cc;
        last_slot = s;
      end
    end
    if (last_slot < 0) begin
      push_status(ST_NONE);
      return;
    end
    for (s = 0; s < total; s++) begin
      if (hit[s]) begin
        rec.slot   = SLOT_W'(s);
        rec.index  = lin[s][IDX_W-1:0];
        rec.status = ST_NEIGHBOR;
        rec.last   = (s == last_slot);
        append_expected(rec);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_neighbors.size() == 0) begin
        $error("unexpected result: slot %0d index %0d status %0d last %0d",
               out_slot, out_neighbor_index, out_status, out_last);
        mismatch_count++;
      end else begin
        head_rec = pending_neighbors.pop_front();
        check_field("slot", 32'(head_rec.slot), 32'(out_slot));
        check_field("neighbor_index", 32'(head_rec.index), 32'(out_neighbor_index));
        check_field("status", 32'(head_rec.status), 32'(out_status));
        check_field("last", 32'(head_rec.last), 32'(out_last));
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [COUNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROW_COUNT:    row_cnt   = data;
      REG_COLUMN_COUNT: col_cnt   = data;
      REG_LAYER_COUNT:  layer_cnt = data;
      REG_NBHD_SIZE:    nbhd_size = data[SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_push <= 1'b0;
    while (pending_neighbors.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [COUNT_W-1:0] rows, cols, layers, size_data);
    wait_for_drain();
    write_register(REG_ROW_COUNT, rows);
    write_register(REG_COLUMN_COUNT, cols);
    write_register(REG_LAYER_COUNT, layers);
    write_register(REG_NBHD_SIZE, size_data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_center(input logic [COORD_W-1:0] r, c, l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push          <= 1'b1;
    in_center_row    <= r;
    in_center_column <= c;
    in_center_layer  <= l;
    @(posedge clk);
    while (in_full) @(posedge clk);
    enumerate_neighbors(r, c, l);
    @(negedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] pick_count();
    int k;
    k = $urandom_range(99);
    if (k < 3) return '0;
    if (k < 35) return COUNT_W'($urandom_range(4, 1));
    if (k < 60) return COUNT_W'($urandom_range(40, 5));
    if (k < 75) return COUNT_W'($urandom_range(1024, 1000));
    if (k < 85) return COUNT_W'($urandom_range(2047, 1025));
    return COUNT_W'($urandom_range(2047, 1));
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int side);
    int k;
    int top;
    k   = $urandom_range(99);
    top = (side > 1023) ? 1023 : side;
    if (k < 10 || side == 0) return COORD_W'($urandom_range(1023));
    if (k < 20) return '0;
    if (k < 30) return COORD_W'(side - 1);
    if (k < 35) return COORD_W'(top);
    if (k < 45) return COORD_W'((side >= 2) ? side - 2 : 0);
    if (k < 55) return COORD_W'(1);
    return COORD_W'($urandom_range(side - 1));
  endfunction

  task automatic test_reset_values();
    send_center(10'd0, 10'd0, 10'd0);
    send_center(10'd0, 10'd1, 10'd0);
  endtask

  task automatic test_bad_size();
    apply_settings(11'd4, 11'd4, 11'd4, 11'(5'd0));
    send_center(10'd1, 10'd1, 10'd1);
    apply_settings(11'd4, 11'd4, 11'd4, 11'(5'd17));
    send_center(10'd1, 10'd2, 10'd1);
    // size error wins over an out-of-range centre
    apply_settings(11'd1, 11'd1, 11'd1, 11'(5'd31));
    send_center(10'd5, 10'd5, 10'd5);
  endtask

  task automatic test_zero_count();
    apply_settings(11'd0, 11'd3, 11'd0, 11'(SIZE_FIRST));
    send_center(10'd0, 10'd0, 10'd0);
  endtask

  task automatic test_clamped_counts();
    apply_settings(11'd1024, 11'd1025, 11'd2047, 11'(SIZE_SECOND));
    send_center(10'd0, 10'd0, 10'd0);
    send_center(10'd1023, 10'd1023, 10'd1023);
    send_center(10'd1023, 10'd0, 10'd1023);
    send_center(10'd0, 10'd1023, 10'd1022);
    send_center(10'd512, 10'd511, 10'd700);
    send_center(10'd1, 10'd1, 10'd0);
  endtask

  task automatic test_small_lattice();
    apply_settings(11'd3, 11'd3, 11'd3, {6'b101010, SIZE_SECOND});
    send_center(10'd1, 10'd1, 10'd1);
    send_center(10'd1, 10'd1, 10'd0);
    send_center(10'd0, 10'd0, 10'd0);
    send_center(10'd2, 10'd2, 10'd2);
    send_center(10'd0, 10'd2, 10'd1);
    apply_settings(11'd5, 11'd5, 11'd5, 11'(SIZE_FIRST));
    send_center(10'd2, 10'd2, 10'd2);
    send_center(10'd2, 10'd2, 10'd1);
    apply_settings(11'd2, 11'd1, 11'd1, 11'(SIZE_FIRST));
    send_center(10'd0, 10'd0, 10'd0);
  endtask

  task automatic test_random_traffic(input int idle_pct, stall_pct);
    int                  phase, n, k;
    logic [SIZE_W-1:0]   size_pick;
    logic [COUNT_W-1:0]  size_data;
    for (phase = 0; phase < 5; phase++) begin
      k = $urandom_range(99);
      if (k < 45) size_pick = SIZE_FIRST;
      else if (k < 90) size_pick = SIZE_SECOND;
      else size_pick = SIZE_W'($urandom_range(31));
      size_data = $urandom_range(1) ? {6'($urandom), size_pick} : 11'(size_pick);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_settings(pick_count(), pick_count(), pick_count(), size_data);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < 22; n++) begin
        send_center(pick_coord(side_of(row_cnt)), pick_coord(side_of(col_cnt)),
                    pick_coord(side_of(layer_cnt)));
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_push          = 1'b0;
    in_center_row    = '0;
    in_center_column = '0;
    in_center_layer  = '0;
    out_pop          = 1'b0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    row_cnt          = COUNT_RESET;
    col_cnt          = COUNT_RESET;
    layer_cnt        = COUNT_RESET;
    nbhd_size        = SIZE_FIRST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_bad_size();
    test_zero_count();
    test_clamped_counts();
    test_small_lattice();
    test_random_traffic(0, 0);
    test_random_traffic(82, 0);
    test_random_traffic(0, 82);
    test_random_traffic(36, 36);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_for_drain();
    if (mismatch_count == 0 && pending_neighbors.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
